// ===== hw/rtl/bts_pkg.sv =====
package bts_pkg;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 2;
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 16;
  localparam int TNUM_W   = 8;
  localparam int SLOT_W   = 5;
  localparam int LEN_W    = 6;
  localparam int POS_W    = 6;
  localparam int PERIOD_W = 10;
  localparam int TOG_W    = 16;
  localparam int NWAIT_W  = 16;
  localparam int NOTE_W   = FREQ_W + DUR_W;
  localparam int DVS_W    = 16;
  localparam int MS_SCALE = 1000;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PLAY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_ZERO_FREQ = 2'd3;

  // Microprogram addresses.
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_IDLE      = 4'd0;
  localparam pc_t PC_TICK_B    = 4'd1;
  localparam pc_t PC_TICK_N    = 4'd2;
  localparam pc_t PC_NOTE_RD   = 4'd3;
  localparam pc_t PC_NOTE_LD   = 4'd4;
  localparam pc_t PC_BCHK      = 4'd5;
  localparam pc_t PC_DIV1L     = 4'd6;
  localparam pc_t PC_DIV1      = 4'd7;
  localparam pc_t PC_DIV2L     = 4'd8;
  localparam pc_t PC_DIV2      = 4'd9;
  localparam pc_t PC_BSET      = 4'd10;
  localparam pc_t PC_NOTE_POST = 4'd11;
  localparam pc_t PC_PLAY      = 4'd12;
  localparam pc_t PC_LOAD      = 4'd13;
  localparam pc_t PC_EMIT      = 4'd14;

  // Datapath operations.
  localparam int OP_W = 4;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_ACCEPT    = 4'd1;
  localparam op_t OP_TICK_BEEP = 4'd2;
  localparam op_t OP_TICK_NOTE = 4'd3;
  localparam op_t OP_NOTE_RD   = 4'd4;
  localparam op_t OP_NOTE_LD   = 4'd5;
  localparam op_t OP_BEEP_CHK  = 4'd6;
  localparam op_t OP_DIV1_LOAD = 4'd7;
  localparam op_t OP_DIV_STEP  = 4'd8;
  localparam op_t OP_DIV2_LOAD = 4'd9;
  localparam op_t OP_BEEP_SET  = 4'd10;
  localparam op_t OP_NOTE_POST = 4'd11;
  localparam op_t OP_PLAY      = 4'd12;
  localparam op_t OP_LOAD      = 4'd13;
  localparam op_t OP_EMIT      = 4'd14;

  // Branch kinds. A conditional branch goes to the target when its condition holds.
  localparam int BR_W = 4;
  typedef logic [BR_W-1:0] br_t;
  localparam br_t BR_GOTO     = 4'd0;
  localparam br_t BR_DISPATCH = 4'd1;
  localparam br_t BR_BEEP_OK  = 4'd2;
  localparam br_t BR_RET      = 4'd3;
  localparam br_t BR_DIV_LOOP = 4'd4;
  localparam br_t BR_NOTE_DUE = 4'd5;
  localparam br_t BR_NOTE_OK  = 4'd6;
  localparam br_t BR_EMIT     = 4'd7;

  typedef struct packed {
    op_t op;
    br_t br;
    pc_t target;
  } ucode_t;

  typedef struct packed {
    logic             in_fire;
    logic [CMD_W-1:0] cmd;
    logic             beep_ok;
    logic             from_note;
    logic             div_last;
    logic             note_due;
    logic             note_ok;
    logic             emit_ok;
  } cond_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUR_W-1:0]  duration_ms;
    logic [TNUM_W-1:0] tune_number;
    logic [SLOT_W-1:0] note_slot;
    logic              final_note;
  } in_word_t;

  typedef struct packed {
    logic       buzzer_level;
    logic [1:0] status;
    logic       beep_active;
    logic       tune_active;
  } out_word_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t uc;
    unique case (pc)
      PC_IDLE:      uc = '{OP_ACCEPT,    BR_DISPATCH, PC_IDLE};
      PC_TICK_B:    uc = '{OP_TICK_BEEP, BR_GOTO,     PC_TICK_N};
      PC_TICK_N:    uc = '{OP_TICK_NOTE, BR_NOTE_DUE, PC_NOTE_RD};
      PC_NOTE_RD:   uc = '{OP_NOTE_RD,   BR_NOTE_OK,  PC_NOTE_LD};
      PC_NOTE_LD:   uc = '{OP_NOTE_LD,   BR_GOTO,     PC_BCHK};
      PC_BCHK:      uc = '{OP_BEEP_CHK,  BR_BEEP_OK,  PC_DIV1L};
      PC_DIV1L:     uc = '{OP_DIV1_LOAD, BR_GOTO,     PC_DIV1};
      PC_DIV1:      uc = '{OP_DIV_STEP,  BR_DIV_LOOP, PC_DIV2L};
      PC_DIV2L:     uc = '{OP_DIV2_LOAD, BR_GOTO,     PC_DIV2};
      PC_DIV2:      uc = '{OP_DIV_STEP,  BR_DIV_LOOP, PC_BSET};
      PC_BSET:      uc = '{OP_BEEP_SET,  BR_RET,      PC_EMIT};
      PC_NOTE_POST: uc = '{OP_NOTE_POST, BR_GOTO,     PC_EMIT};
      PC_PLAY:      uc = '{OP_PLAY,      BR_GOTO,     PC_EMIT};
      PC_LOAD:      uc = '{OP_LOAD,      BR_GOTO,     PC_EMIT};
      PC_EMIT:      uc = '{OP_EMIT,      BR_EMIT,     PC_IDLE};
      default:      uc = '{OP_NOP,       BR_GOTO,     PC_IDLE};
    endcase
    return uc;
  endfunction

endpackage

// ===== hw/rtl/bts_seq.sv =====
module bts_seq
  import bts_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cond_t  cond,
  output pc_t    pc,
  output ucode_t uc
);

  pc_t pc_r;
  pc_t pc_nxt;

  assign pc = pc_r;
  assign uc = ucode_rom(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    unique case (uc.br)
      BR_GOTO: pc_nxt = uc.target;
      BR_DISPATCH: begin
        if (cond.in_fire) begin
          unique case (cond.cmd)
            CMD_TICK: pc_nxt = PC_TICK_B;
            CMD_BEEP: pc_nxt = PC_BCHK;
            CMD_PLAY: pc_nxt = PC_PLAY;
            CMD_LOAD: pc_nxt = PC_LOAD;
            default:  pc_nxt = PC_IDLE;
          endcase
        end
      end
      BR_BEEP_OK: begin
        if (cond.beep_ok) begin
          pc_nxt = uc.target;
        end else begin
          pc_nxt = cond.from_note ? PC_NOTE_POST : PC_EMIT;
        end
      end
      BR_RET:      pc_nxt = cond.from_note ? PC_NOTE_POST : PC_EMIT;
      BR_DIV_LOOP: pc_nxt = cond.div_last ? uc.target : pc_r;
      BR_NOTE_DUE: pc_nxt = cond.note_due ? uc.target : PC_EMIT;
      BR_NOTE_OK:  pc_nxt = cond.note_ok ? uc.target : PC_EMIT;
      BR_EMIT:     pc_nxt = cond.emit_ok ? uc.target : pc_r;
      default:     pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hw/rtl/bts_div.sv =====
module bts_div
  import bts_pkg::*;
#(
  parameter int DVD_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             last
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;

  // One quotient bit per step, restoring form.
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (ctl.step) begin
      if (!diff[DVS_W+1]) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (ctl.load) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign last     = (cnt_r == CNT_W'(1));

endmodule

// ===== hw/rtl/bts_note_mem.sv =====
module bts_note_mem
  import bts_pkg::*;
#(
  parameter int NUM_TUNES = 4,
  parameter int MAX_NOTES = 32,
  localparam int DEPTH    = NUM_TUNES * MAX_NOTES,
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int TIDX_W   = (NUM_TUNES > 1) ? $clog2(NUM_TUNES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [NOTE_W-1:0] wr_data,
  input  logic              len_wr_en,
  input  logic [TIDX_W-1:0] wr_tune,
  input  logic [LEN_W-1:0]  len_wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [TIDX_W-1:0] rd_tune,
  output logic [NOTE_W-1:0] rd_data,
  output logic [LEN_W-1:0]  rd_len
);

  logic [NOTE_W-1:0] note_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem [NUM_TUNES];
  logic [NUM_TUNES-1:0] len_vld_r;
  logic [NOTE_W-1:0] rd_data_r;
  logic [LEN_W-1:0]  len_q_r;
  logic              vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[wr_addr] <= wr_data;
    end
    if (len_wr_en) begin
      len_mem[wr_tune] <= len_wr_data;
    end
    if (rd_en) begin
      rd_data_r <= note_mem[rd_addr];
      len_q_r   <= len_mem[rd_tune];
    end
  end

  // A tune length that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      if (len_wr_en) begin
        len_vld_r[wr_tune] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= len_vld_r[rd_tune];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_len  = vld_q_r ? len_q_r : '0;

endmodule

// ===== hw/rtl/buzzer_tone_melody_sequencer.sv =====
// Channel   Dir  Handshake          Word
// in_       in   in_valid/in_stall  in_word_t: command, frequency, duration, tune, slot, final
// out_      out  out_valid/out_stall out_word_t: pin level, status, beep and tune flags
//
// Play, load, a refused beep and a plain tick pass idle, their own steps and emit. An accepted
// beep runs the shared divider for the period, then the toggles, one quotient bit per cycle of
// a DVD_W = 16 + clog2(TICKS_PER_MS + 1) bit dividend. A tick that reaches a note reads it and
// beeps the same way; it skips the divider if the beep is dropped, and the beep if the melody
// has run out. Synchronous active-low reset clears beep, melody and tune lengths. Results wait
// in an output register; a stalled output holds only the next word's final step.
module buzzer_tone_melody_sequencer
  import bts_pkg::*;
#(
  parameter int NUM_TUNES    = 4,
  parameter int MAX_NOTES    = 32,
  parameter int TICKS_PER_MS = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int DEPTH    = NUM_TUNES * MAX_NOTES;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIDX_W   = (NUM_TUNES > 1) ? $clog2(NUM_TUNES) : 1;
  localparam int DVD_W    = 16 + $clog2(TICKS_PER_MS + 1);
  localparam int DVD_INIT = MS_SCALE * TICKS_PER_MS;

  pc_t    pc;
  ucode_t uc;
  cond_t  cond;

  // Latched input word.
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic [TNUM_W-1:0] tune_r, tune_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              fin_r, fin_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              from_note_r, from_note_nxt;

  // Beep and melody state.
  logic                pin_r, pin_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [TOG_W-1:0]    tog_r, tog_nxt;
  logic [PERIOD_W-1:0] beep_cnt_r, beep_cnt_nxt;
  logic                beep_run_r, beep_run_nxt;
  logic                mel_run_r, mel_run_nxt;
  logic [TIDX_W-1:0]   act_tune_r, act_tune_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [NWAIT_W-1:0]  note_cnt_r, note_cnt_nxt;

  logic      out_valid_r;
  out_word_t out_data_r;

  // Divider and note memory hookup.
  div_ctl_t          div_ctl;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_quo;
  logic              div_last;

  logic              mem_wr_en, len_wr_en, mem_rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [TIDX_W-1:0] wr_tune;
  logic [NOTE_W-1:0] rd_data;
  logic [LEN_W-1:0]  rd_len;

  logic                tune_bad, slot_bad, note_ok, emit_ok;
  logic [DVD_W-1:0]    dur_tpm;
  logic [PERIOD_W-1:0] period_sat;
  logic [TOG_W-1:0]    tog_sat;
  logic [NWAIT_W-1:0]  wait_sat;
  logic [POS_W-1:0]    pos_inc;

  assign in_stall = (pc != PC_IDLE);
  assign emit_ok  = !out_valid_r || !out_stall;

  assign tune_bad = (tune_r >= TNUM_W'(NUM_TUNES));
  assign slot_bad = ({4'd0, slot_r} >= 9'(MAX_NOTES));
  assign note_ok  = (32'(act_tune_r) < NUM_TUNES) && ({3'd0, pos_r} < 9'(MAX_NOTES));

  assign wr_tune = TIDX_W'(tune_r);
  assign wr_addr = ADDR_W'(32'(wr_tune) * MAX_NOTES + 32'(slot_r));
  assign rd_addr = ADDR_W'(32'(act_tune_r) * MAX_NOTES + 32'(pos_r));

  // Scaled duration, used both as the second dividend and as the note wait.
  assign dur_tpm  = DVD_W'(32'(dur_r) * TICKS_PER_MS);
  assign wait_sat = (|dur_tpm[DVD_W-1:NWAIT_W]) ? '1 : dur_tpm[NWAIT_W-1:0];

  // The first quotient is the half period, held between one and its ceiling.
  always_comb begin
    if (div_quo == '0) begin
      period_sat = PERIOD_W'(1);
    end else if (|div_quo[DVD_W-1:PERIOD_W]) begin
      period_sat = PERIOD_MAX;
    end else begin
      period_sat = div_quo[PERIOD_W-1:0];
    end
  end

  assign tog_sat = (|div_quo[DVD_W-1:TOG_W]) ? '1 : div_quo[TOG_W-1:0];
  assign pos_inc = pos_r + 1'b1;

  assign cond.in_fire   = in_valid && !in_stall;
  assign cond.cmd       = in_data.command;
  assign cond.beep_ok   = (tog_r == '0) && (freq_r != '0);
  assign cond.from_note = from_note_r;
  assign cond.div_last  = div_last;
  assign cond.note_due  = mel_run_r && (note_cnt_r <= NWAIT_W'(1));
  assign cond.note_ok   = note_ok;
  assign cond.emit_ok   = emit_ok;

  bts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .pc    (pc),
    .uc    (uc)
  );

  bts_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .last     (div_last)
  );

  bts_note_mem #(
    .NUM_TUNES (NUM_TUNES),
    .MAX_NOTES (MAX_NOTES)
  ) u_note_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (mem_wr_en),
    .wr_addr     (wr_addr),
    .wr_data     ({dur_r, freq_r}),
    .len_wr_en   (len_wr_en),
    .wr_tune     (wr_tune),
    .len_wr_data (LEN_W'({1'b0, slot_r} + 6'd1)),
    .rd_en       (mem_rd_en),
    .rd_addr     (rd_addr),
    .rd_tune     (act_tune_r),
    .rd_data     (rd_data),
    .rd_len      (rd_len)
  );

  // Datapath: the control word of the current step selects one operation.
  always_comb begin
    cmd_nxt       = cmd_r;
    freq_nxt      = freq_r;
    dur_nxt       = dur_r;
    tune_nxt      = tune_r;
    slot_nxt      = slot_r;
    fin_nxt       = fin_r;
    st_nxt        = st_r;
    from_note_nxt = from_note_r;
    pin_nxt       = pin_r;
    period_nxt    = period_r;
    tog_nxt       = tog_r;
    beep_cnt_nxt  = beep_cnt_r;
    beep_run_nxt  = beep_run_r;
    mel_run_nxt   = mel_run_r;
    act_tune_nxt  = act_tune_r;
    pos_nxt       = pos_r;
    note_cnt_nxt  = note_cnt_r;
    div_ctl       = '0;
    div_dvd       = '0;
    div_dvs       = '0;
    mem_wr_en     = 1'b0;
    len_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;

    unique case (uc.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          cmd_nxt       = in_data.command;
          freq_nxt      = in_data.frequency_hz;
          dur_nxt       = in_data.duration_ms;
          tune_nxt      = in_data.tune_number;
          slot_nxt      = in_data.note_slot;
          fin_nxt       = in_data.final_note;
          st_nxt        = ST_OK;
          from_note_nxt = 1'b0;
        end
      end
      OP_TICK_BEEP: begin
        // Pin event when the countdown runs out; the last one drives the pin low.
        if (beep_run_r) begin
          if (beep_cnt_r <= PERIOD_W'(1)) begin
            if (tog_r == '0) begin
              pin_nxt      = 1'b0;
              beep_run_nxt = 1'b0;
            end else begin
              tog_nxt      = tog_r - 1'b1;
              pin_nxt      = !pin_r;
              beep_cnt_nxt = period_r;
            end
          end else begin
            beep_cnt_nxt = beep_cnt_r - 1'b1;
          end
        end
      end
      OP_TICK_NOTE: begin
        if (mel_run_r && (note_cnt_r > NWAIT_W'(1))) begin
          note_cnt_nxt = note_cnt_r - 1'b1;
        end
      end
      OP_NOTE_RD: begin
        mem_rd_en = note_ok;
        if (!note_ok) begin
          mel_run_nxt = 1'b0;
        end
      end
      OP_NOTE_LD: begin
        freq_nxt      = rd_data[FREQ_W-1:0];
        dur_nxt       = rd_data[NOTE_W-1:FREQ_W];
        from_note_nxt = 1'b1;
      end
      OP_BEEP_CHK: begin
        // Melody notes fail silently; only a direct request reports.
        if (!from_note_r) begin
          if (tog_r != '0) begin
            st_nxt = ST_BUSY;
          end else if (freq_r == '0) begin
            st_nxt = ST_ZERO_FREQ;
          end else begin
            st_nxt = ST_OK;
          end
        end
      end
      OP_DIV1_LOAD: begin
        div_ctl.load = 1'b1;
        div_dvd      = DVD_W'(DVD_INIT);
        div_dvs      = freq_r;
      end
      OP_DIV_STEP: begin
        div_ctl.step = 1'b1;
      end
      OP_DIV2_LOAD: begin
        period_nxt   = period_sat;
        div_ctl.load = 1'b1;
        div_dvd      = dur_tpm;
        div_dvs      = DVS_W'(period_sat);
      end
      OP_BEEP_SET: begin
        pin_nxt      = 1'b1;
        tog_nxt      = tog_sat;
        beep_cnt_nxt = period_r;
        beep_run_nxt = 1'b1;
      end
      OP_NOTE_POST: begin
        pos_nxt = pos_inc;
        if (pos_inc < rd_len) begin
          note_cnt_nxt = wait_sat;
        end else begin
          mel_run_nxt = 1'b0;
        end
      end
      OP_PLAY: begin
        if (tune_bad) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          act_tune_nxt = TIDX_W'(tune_r);
          pos_nxt      = '0;
          note_cnt_nxt = '0;
          mel_run_nxt  = 1'b1;
        end
      end
      OP_LOAD: begin
        if (tune_bad || slot_bad) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          mem_wr_en = 1'b1;
          len_wr_en = fin_r;
        end
      end
      OP_EMIT: begin
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r       <= 1'b0;
      period_r    <= '0;
      tog_r       <= '0;
      beep_cnt_r  <= '0;
      beep_run_r  <= 1'b0;
      mel_run_r   <= 1'b0;
      act_tune_r  <= '0;
      pos_r       <= '0;
      note_cnt_r  <= '0;
      st_r        <= ST_OK;
      from_note_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pin_r       <= pin_nxt;
      period_r    <= period_nxt;
      tog_r       <= tog_nxt;
      beep_cnt_r  <= beep_cnt_nxt;
      beep_run_r  <= beep_run_nxt;
      mel_run_r   <= mel_run_nxt;
      act_tune_r  <= act_tune_nxt;
      pos_r       <= pos_nxt;
      note_cnt_r  <= note_cnt_nxt;
      st_r        <= st_nxt;
      from_note_r <= from_note_nxt;
      if ((uc.op == OP_EMIT) && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    freq_r <= freq_nxt;
    dur_r  <= dur_nxt;
    tune_r <= tune_nxt;
    slot_r <= slot_nxt;
    fin_r  <= fin_nxt;
    if ((uc.op == OP_EMIT) && emit_ok) begin
      out_data_r.buzzer_level <= pin_r;
      out_data_r.status       <= st_r;
      out_data_r.beep_active  <= beep_run_r;
      out_data_r.tune_active  <= mel_run_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A toggle budget only exists while its beep is running.
  a_tog_needs_beep: assert property (@(posedge clk) disable iff (!rst_n)
    (tog_r != '0) |-> beep_run_r)
    else $error("toggle budget left without a running beep");

  // A running beep always has a usable half period.
  a_period_set: assert property (@(posedge clk) disable iff (!rst_n)
    beep_run_r |-> (period_r != '0))
    else $error("running beep with zero period");

  // The divider never runs on a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc == PC_DIV1) |-> (freq_r != '0)) and ((pc == PC_DIV2) |-> (period_r != '0)))
    else $error("division started with zero divisor");

  // The command that steered the dispatch is the one latched for the item.
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (pc == PC_PLAY) |-> (cmd_r == CMD_PLAY))
    else $error("play step reached for another command");

endmodule

// ===== tb/melody_checker.sv =====
module melody_checker
  import bts_pkg::*;
#(
  parameter int NUM_TUNES    = 4,
  parameter int MAX_NOTES    = 32,
  parameter int TICKS_PER_MS = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        mismatches,
  output int        words_pending
);

  localparam int NOTE_SLOTS = NUM_TUNES * MAX_NOTES;

  // Shadow copy of the sequencer state.
  logic                pin;
  logic [PERIOD_W-1:0] half_period;
  logic [PERIOD_W-1:0] beep_wait;
  logic [TOG_W-1:0]    toggles;
  logic                beeping;
  logic                playing;
  int unsigned         cur_tune;
  int unsigned         note_pos;
  logic [NWAIT_W-1:0]  note_wait;
  logic [NOTE_W-1:0]   note_mem [NOTE_SLOTS];
  logic [LEN_W-1:0]    tune_len [NUM_TUNES];

  out_word_t expected_words [$];
  int        errors;

  task automatic clear_state();
    pin         = 1'b0;
    half_period = '0;
    beep_wait   = '0;
    toggles     = '0;
    beeping     = 1'b0;
    playing     = 1'b0;
    cur_tune    = 0;
    note_pos    = 0;
    note_wait   = '0;
    for (int i = 0; i < NUM_TUNES; i++) tune_len[i] = '0;
  endtask

  // Starts a tone unless toggles are still owed or the frequency is zero.
  task automatic start_tone(input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                            output logic [1:0] st);
    longint unsigned p;
    longint unsigned t;
    if (toggles != 0) begin
      st = ST_BUSY;
    end else if (freq == 0) begin
      st = ST_ZERO_FREQ;
    end else begin
      p = 64'(MS_SCALE * TICKS_PER_MS) / 64'(freq);
      if (p < 1) p = 1;
      if (p > 64'(PERIOD_MAX)) p = 64'(PERIOD_MAX);
      t = (longint'(dur) * TICKS_PER_MS) / p;
      if (t > 65535) t = 65535;
      pin         = 1'b1;
      half_period = PERIOD_W'(p);
      beep_wait   = PERIOD_W'(p);
      toggles     = TOG_W'(t);
      beeping     = 1'b1;
      st          = ST_OK;
    end
  endtask

  task automatic tone_expiry();
    if (toggles == 0) begin
      pin     = 1'b0;
      beeping = 1'b0;
    end else begin
      toggles   = toggles - 1'b1;
      pin       = ~pin;
      beep_wait = half_period;
    end
  endtask

  task automatic advance_note();
    logic [NOTE_W-1:0] entry;
    logic [1:0]        dropped;
    longint unsigned   wait_ticks;
    if (cur_tune >= NUM_TUNES || note_pos >= MAX_NOTES) begin
      playing = 1'b0;
      return;
    end
    entry = note_mem[cur_tune * MAX_NOTES + note_pos];
    start_tone(entry[FREQ_W-1:0], entry[NOTE_W-1:FREQ_W], dropped);
    note_pos++;
    if (note_pos < tune_len[cur_tune]) begin
      wait_ticks = longint'(entry[NOTE_W-1:FREQ_W]) * TICKS_PER_MS;
      if (wait_ticks > 65535) wait_ticks = 65535;
      note_wait = NWAIT_W'(wait_ticks);
    end else begin
      playing = 1'b0;
    end
  endtask

  task automatic predict_word(input in_word_t w, output out_word_t r);
    logic [1:0] st;
    st = ST_OK;
    case (w.command)
      CMD_TICK: begin
        // The tone is served before the melody within one tick.
        if (beeping) begin
          if (beep_wait <= 1) tone_expiry();
          else beep_wait = beep_wait - 1'b1;
        end
        if (playing) begin
          if (note_wait <= 1) advance_note();
          else note_wait = note_wait - 1'b1;
        end
      end
      CMD_BEEP: start_tone(w.frequency_hz, w.duration_ms, st);
      CMD_PLAY: begin
        if (w.tune_number >= NUM_TUNES) begin
          st = ST_OVERFLOW;
        end else begin
          cur_tune  = 32'(w.tune_number);
          note_pos  = 0;
          note_wait = '0;
          playing   = 1'b1;
        end
      end
      default: begin
        if (w.tune_number >= NUM_TUNES || w.note_slot >= MAX_NOTES) begin
          st = ST_OVERFLOW;
        end else begin
          note_mem[w.tune_number * MAX_NOTES + w.note_slot] = {w.duration_ms, w.frequency_hz};
          if (w.final_note) tune_len[w.tune_number] = LEN_W'(w.note_slot + 1);
        end
      end
    endcase
    r.buzzer_level = pin;
    r.status       = st;
    r.beep_active  = beeping;
    r.tune_active  = playing;
  endtask

  task automatic check_field(input string name, input logic [1:0] want_v, input logic [1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_state();
      expected_words.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_word(in_data, want);
        expected_words.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %p",
                   $time, out_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("buzzer_level", 2'(want.buzzer_level), 2'(out_data.buzzer_level));
          check_field("status", want.status, out_data.status);
          check_field("beep_active", 2'(want.beep_active), 2'(out_data.beep_active));
          check_field("tune_active", 2'(want.tune_active), 2'(out_data.tune_active));
        end
      end
    end
    mismatches    <= errors;
    words_pending <= expected_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the buzzer sequencer bench. It makes stimulus and gives the verdict;
// the checker beside the block predicts every result word and compares it.
module testbench;
  import bts_pkg::*;

  localparam int NUM_TUNES    = 4;
  localparam int MAX_NOTES    = 32;
  localparam int TICKS_PER_MS = 1;
  localparam int RANDOM_WORDS = 1750;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  int        mismatches;
  int        words_pending;

  // Calm phases switch off idling on one side for a while.
  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;
  int stall_hold = 0;

  // The note table has no reset value, so the stimulus keeps track of which
  // entries it has loaded and never lets a melody reach an empty one.
  bit note_loaded [NUM_TUNES][MAX_NOTES];
  int loaded_len  [NUM_TUNES];
  int random_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buzzer_tone_melody_sequencer #(
    .NUM_TUNES   (NUM_TUNES),
    .MAX_NOTES   (MAX_NOTES),
    .TICKS_PER_MS(TICKS_PER_MS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  melody_checker #(
    .NUM_TUNES   (NUM_TUNES),
    .MAX_NOTES   (MAX_NOTES),
    .TICKS_PER_MS(TICKS_PER_MS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .words_pending(words_pending)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The result side stalls in bursts of random length, except in calm phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!calm_out && $urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= idle_length();
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 5);
    end
  end

  // Frequencies lean toward short half-periods so that tones toggle often,
  // but the long periods and the zero frequency show up as well.
  function automatic logic [FREQ_W-1:0] tone_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 60) return FREQ_W'($urandom_range(100, 1000));
    if (r < 75) return FREQ_W'($urandom_range(20, 99));
    if (r < 85) return FREQ_W'($urandom_range(1, 19));
    return FREQ_W'($urandom_range(1001, 65535));
  endfunction

  // Short durations keep tones from blocking the buzzer for long stretches.
  function automatic logic [DUR_W-1:0] tone_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 92) return DUR_W'($urandom_range(1, 30));
    return DUR_W'($urandom_range(31, 150));
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.command      = CMD_W'($urandom_range(0, 3));
    w.frequency_hz = FREQ_W'($urandom_range(0, 65535));
    w.duration_ms  = DUR_W'($urandom_range(0, 65535));
    w.tune_number  = TNUM_W'($urandom_range(0, 255));
    w.note_slot    = SLOT_W'($urandom_range(0, 31));
    w.final_note   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic in_word_t word_of(logic [CMD_W-1:0] cmd, int freq, int dur, int tune,
                                       int slot, bit fin);
    in_word_t w;
    w.command      = cmd;
    w.frequency_hz = FREQ_W'(freq);
    w.duration_ms  = DUR_W'(dur);
    w.tune_number  = TNUM_W'(tune);
    w.note_slot    = SLOT_W'(slot);
    w.final_note   = fin;
    return w;
  endfunction

  // Number of loaded slots at the start of a tune, counted without a hole.
  function automatic int loaded_prefix(int t);
    int n;
    n = 0;
    while (n < MAX_NOTES && note_loaded[t][n]) n++;
    return n;
  endfunction

  // A tune may be played only if every note it can reach has been loaded;
  // an empty tune still sounds its first slot.
  function automatic bit tune_ready(int t);
    return note_loaded[t][0] && loaded_prefix(t) >= loaded_len[t];
  endfunction

  // Drives one word and returns at the clock edge that accepts it. The valid
  // stays high into the next call when no gap follows, so it is never lowered
  // and raised within one time step.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = calm_in ? 0 : idle_length();
    if (w.command == CMD_LOAD && w.tune_number < NUM_TUNES && w.note_slot < MAX_NOTES) begin
      note_loaded[w.tune_number][w.note_slot] = 1'b1;
      if (w.final_note) loaded_len[w.tune_number] = w.note_slot + 1;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_ticks(input int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w = random_word();
      w.command = CMD_TICK;
      send_word(w);
      random_sent++;
    end
  endtask

  // Holds the input back until every word sent so far has its result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  initial begin
    in_word_t w;
    int r;
    int t;
    int n;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. A zero frequency is refused, then a fast tone of three
    // toggles starts and a request during those toggles is refused as busy.
    send_word(word_of(CMD_BEEP, 0, 65535, 0, 0, 0));
    send_word(word_of(CMD_BEEP, 1000, 3, 0, 0, 0));
    send_word(word_of(CMD_BEEP, 65535, 65535, 255, 31, 1));
    repeat (3) send_word(word_of(CMD_TICK, 0, 0, 0, 0, 0));
    // Toggles are spent but the pin has not dropped yet, so this restarts.
    send_word(word_of(CMD_BEEP, 500, 4, 0, 0, 0));
    repeat (6) send_word(word_of(CMD_TICK, 0, 0, 0, 0, 0));
    // The longest half-period, with no toggles at all.
    send_word(word_of(CMD_BEEP, 1, 0, 0, 0, 0));
    // Tune numbers past the table are refused for play and for load.
    send_word(word_of(CMD_PLAY, 0, 0, 200, 0, 0));
    send_word(word_of(CMD_LOAD, 440, 10, 4, 0, 1));
    // A tune of length zero still plays its first slot once.
    send_word(word_of(CMD_LOAD, 100, 2, 0, 0, 0));
    send_word(word_of(CMD_PLAY, 0, 0, 0, 0, 0));
    send_word(word_of(CMD_TICK, 0, 0, 0, 0, 0));
    // A silent note is skipped, and a second play restarts the melody.
    send_word(word_of(CMD_LOAD, 0, 1, 3, 0, 0));
    send_word(word_of(CMD_LOAD, 250, 2, 3, 1, 1));
    send_word(word_of(CMD_PLAY, 0, 0, 3, 0, 0));
    send_word(word_of(CMD_PLAY, 0, 0, 3, 0, 0));
    repeat (3) send_word(word_of(CMD_TICK, 0, 0, 0, 0, 0));
    drain();

    // Random part: mostly tick runs, tones and well-formed melodies, with
    // refused commands and odd loads mixed in.
    while (random_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_ticks(($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12));
      end else if (r < 62) begin
        w = random_word();
        w.command      = CMD_BEEP;
        w.frequency_hz = tone_freq();
        w.duration_ms  = tone_dur();
        send_word(w);
        random_sent++;
      end else if (r < 72) begin
        // Load a melody slot by slot, usually marking the last note.
        t = $urandom_range(0, NUM_TUNES - 1);
        n = ($urandom_range(0, 19) == 0) ? MAX_NOTES : $urandom_range(1, 8);
        for (int s = 0; s < n; s++) begin
          w = random_word();
          w.command      = CMD_LOAD;
          w.tune_number  = TNUM_W'(t);
          w.note_slot    = SLOT_W'(s);
          w.frequency_hz = tone_freq();
          w.duration_ms  = tone_dur();
          w.final_note   = (s == n - 1) && ($urandom_range(0, 4) != 0);
          send_word(w);
          random_sent++;
        end
        if ($urandom_range(0, 1) == 1 && tune_ready(t)) begin
          w = random_word();
          w.command     = CMD_PLAY;
          w.tune_number = TNUM_W'(t);
          send_word(w);
          random_sent++;
        end
      end else if (r < 82) begin
        w = random_word();
        w.command = CMD_PLAY;
        if ($urandom_range(0, 5) == 0) begin
          w.tune_number = TNUM_W'($urandom_range(NUM_TUNES, 255));
        end else begin
          w.tune_number = TNUM_W'($urandom_range(0, NUM_TUNES - 1));
        end
        if (w.tune_number >= NUM_TUNES || tune_ready(int'(w.tune_number))) begin
          send_word(w);
          random_sent++;
        end
      end else if (r < 90) begin
        // A single load anywhere. Long notes are kept silent so that they
        // only hold up the melody, which a later play can restart.
        w = random_word();
        w.command = CMD_LOAD;
        if ($urandom_range(0, 4) != 0) begin
          w.tune_number = TNUM_W'($urandom_range(0, NUM_TUNES - 1));
        end
        if ($urandom_range(0, 1) == 1) begin
          w.frequency_hz = tone_freq();
          w.duration_ms  = tone_dur();
        end else begin
          w.frequency_hz = '0;
        end
        if (w.tune_number < NUM_TUNES && w.final_note &&
            loaded_prefix(int'(w.tune_number)) < int'(w.note_slot)) begin
          w.final_note = 1'b0;
        end
        send_word(w);
        random_sent++;
      end else if (r < 95) begin
        // Refused commands with random content.
        w = random_word();
        case ($urandom_range(0, 2))
          0: begin
            w.command      = CMD_BEEP;
            w.frequency_hz = '0;
          end
          1: begin
            w.command     = CMD_PLAY;
            w.tune_number = TNUM_W'($urandom_range(NUM_TUNES, 255));
          end
          default: begin
            w.command     = CMD_LOAD;
            w.tune_number = TNUM_W'($urandom_range(NUM_TUNES, 255));
          end
        endcase
        send_word(w);
        random_sent++;
      end else if (r < 97) begin
        drain();
      end else begin
        if ($urandom_range(0, 1) == 1) calm_in = ~calm_in;
        else calm_out = ~calm_out;
      end
    end

    // Close with the largest tone request from an idle block.
    drain();
    send_word(word_of(CMD_BEEP, 65535, 65535, 0, 0, 0));
    send_ticks(5);
    in_valid <= 1'b0;

    @(posedge clk);
    n = 0;
    while (words_pending != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    // Leave room for a late, unexpected word to show up.
    repeat (60) @(posedge clk);

    if (mismatches == 0 && words_pending == 0) begin
      $display("buzzer_tone_melody_sequencer test passed");
    end else begin
      $display("buzzer_tone_melody_sequencer test failed");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("buzzer_tone_melody_sequencer test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bts_pkg.sv
hw/rtl/bts_seq.sv
hw/rtl/bts_div.sv
hw/rtl/bts_note_mem.sv
hw/rtl/buzzer_tone_melody_sequencer.sv
tb/melody_checker.sv
tb/testbench.sv
